// File: rtl/ptu_pkg.sv
// ptu_pkg: shared types, widths, register reset values and prediction helpers
// for the point track update block. No dependencies.
package ptu_pkg;

  // coordinate widths
  localparam int ImgW = 16;
  localparam int WldW = 24;

  // configuration register widths
  localparam int MissW    = 8;
  localparam int ImgDistW = 35;
  localparam int WldDistW = 51;
  localparam int LenW     = 16;

  // configuration register reset values
  localparam logic [MissW-1:0]    MaxMissedRst = 8'd5;
  localparam logic [ImgDistW-1:0] MaxImgRst    = 35'd6400;
  localparam logic [WldDistW-1:0] MaxWldRst    = 51'd65536;

  // request kinds
  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_PUSH  = 2'd1,
    REQ_CHECK = 2'd2
  } req_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAX_MISSED = 2'd0,
    CFG_MAX_IMG    = 2'd1,
    CFG_MAX_WLD    = 2'd2
  } cfg_idx_t;

  // constant velocity step for image coordinates: 2*cur - prev, saturated
  function automatic logic signed [ImgW-1:0] pred_img(
    input logic signed [ImgW-1:0] cur,
    input logic signed [ImgW-1:0] prev
  );
    logic signed [ImgW+1:0] t;
    t = {cur[ImgW-1], cur, 1'b0} - {{2{prev[ImgW-1]}}, prev};
    if (t[ImgW+1:ImgW-1] == 3'b000 || t[ImgW+1:ImgW-1] == 3'b111) begin
      pred_img = t[ImgW-1:0];
    end else begin
      pred_img = t[ImgW+1] ? {1'b1, {(ImgW-1){1'b0}}} : {1'b0, {(ImgW-1){1'b1}}};
    end
  endfunction

  // constant velocity step for world coordinates: 2*cur - prev, saturated
  function automatic logic signed [WldW-1:0] pred_wld(
    input logic signed [WldW-1:0] cur,
    input logic signed [WldW-1:0] prev
  );
    logic signed [WldW+1:0] t;
    t = {cur[WldW-1], cur, 1'b0} - {{2{prev[WldW-1]}}, prev};
    if (t[WldW+1:WldW-1] == 3'b000 || t[WldW+1:WldW-1] == 3'b111) begin
      pred_wld = t[WldW-1:0];
    end else begin
      pred_wld = t[WldW+1] ? {1'b1, {(WldW-1){1'b0}}} : {1'b0, {(WldW-1){1'b1}}};
    end
  endfunction

endpackage

// File: rtl/ptu_dist.sv
// ptu_dist: squared euclidean distance between two signed 2-d points,
// dx*dx + dy*dy, unsigned result. No dependencies.
module ptu_dist #(
  parameter int W = 16
) (
  input  logic signed [W-1:0] ax,
  input  logic signed [W-1:0] ay,
  input  logic signed [W-1:0] bx,
  input  logic signed [W-1:0] by,
  output logic [2*W+1:0]      sq_sum
);

  logic signed [W:0]     dx;
  logic signed [W:0]     dy;
  logic signed [2*W+1:0] sqx;
  logic signed [2*W+1:0] sqy;

  // differences, one bit wider than the coordinates
  assign dx = {ax[W-1], ax} - {bx[W-1], bx};
  assign dy = {ay[W-1], ay} - {by[W-1], by};

  // squares are never negative and stay below 2**(2W), so the sum fits
  assign sqx = dx * dx;
  assign sqy = dy * dy;

  assign sq_sum = sqx + sqy;

endmodule

// File: rtl/point_track_update.sv
// point_track_update: constant velocity predictor for one tracked path.
// Depends on ptu_pkg and ptu_dist.
//
// channel | direction | handshake            | payload
// --------+-----------+----------------------+------------------------------------
// in_     | slave     | in_tvalid/in_tready  | in_tdata 80b point, in_tuser req
// out_    | master    | out_tvalid/out_tready| out_tdata 160b track status
// cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index 2b, cfg_data 51b
//
// One beat in per cycle while the result side is not stalled, one result beat
// out per input beat. Each item passes the input register, then the state and result register.
// Path state and predictions update in the cycle the item moves into the
// result register, so items follow back to back with no hazard.
// A stalled result holds; the input register still takes one more beat.
// Synchronous active-low reset clears path state and valid flags and loads configuration reset values.
module point_track_update (
  input  logic         clk,
  input  logic         rst_n,
  // input beat
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,   // img_x[15:0] img_y[31:16] world_x[55:32] world_y[79:56]
  input  logic [1:0]   in_tuser,   // req_type[1:0]
  // result beat
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // remove_track[0] missed_count[8:1] track_length[24:9]
                                   // max_dist_sq[75:25] pred_img_x[91:76] pred_img_y[107:92]
                                   // pred_world_x[131:108] pred_world_y[155:132]
                                   // image_near[156] world_near[157] zero[159:158]
  // configuration
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [50:0]  cfg_data
);

  localparam int ImgW = ptu_pkg::ImgW;
  localparam int WldW = ptu_pkg::WldW;

  // configuration registers
  logic [ptu_pkg::MissW-1:0]    max_missed_r;
  logic [ptu_pkg::ImgDistW-1:0] max_img_r;
  logic [ptu_pkg::WldDistW-1:0] max_wld_r;

  // input register
  logic                   s1_valid_r;
  ptu_pkg::req_t          s1_req_r;
  logic signed [ImgW-1:0] s1_ix_r, s1_iy_r;
  logic signed [WldW-1:0] s1_wx_r, s1_wy_r;

  // path state
  logic signed [ImgW-1:0] last_ix_r, last_iy_r, guess_ix_r, guess_iy_r;
  logic signed [WldW-1:0] last_wx_r, last_wy_r, guess_wx_r, guess_wy_r;
  logic signed [WldW-1:0] origin_wx_r, origin_wy_r;
  logic [ptu_pkg::MissW-1:0]    miss_run_r;
  logic [ptu_pkg::LenW-1:0]     frame_total_r;
  logic [ptu_pkg::WldDistW-1:0] far_r;

  logic signed [ImgW-1:0] last_ix_nxt, last_iy_nxt, guess_ix_nxt, guess_iy_nxt;
  logic signed [WldW-1:0] last_wx_nxt, last_wy_nxt, guess_wx_nxt, guess_wy_nxt;
  logic signed [WldW-1:0] origin_wx_nxt, origin_wy_nxt;
  logic [ptu_pkg::MissW-1:0]    miss_run_nxt;
  logic [ptu_pkg::LenW-1:0]     frame_total_nxt;
  logic [ptu_pkg::WldDistW-1:0] far_nxt;

  // result register flags
  logic out_valid_r;
  logic remove_r, inear_r, wnear_r;
  logic remove_nxt, inear_nxt, wnear_nxt;

  // handshake control
  logic adv;
  logic load;

  // distance unit outputs
  logic signed [WldW-1:0] wld_bx, wld_by;
  logic [2*ImgW+1:0]      img_sq;
  logic [2*WldW+1:0]      wld_sq;

  // helpers for the push path
  logic                         prev_ok;
  logic                         missed;
  logic [ptu_pkg::MissW-1:0]    miss_inc;
  logic [ptu_pkg::WldDistW-1:0] wld_sq_ext;

  // pipeline flow: result slot frees when empty or taken
  assign adv       = !out_valid_r || out_tready;
  assign load      = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_missed_r <= ptu_pkg::MaxMissedRst;
      max_img_r    <= ptu_pkg::MaxImgRst;
      max_wld_r    <= ptu_pkg::MaxWldRst;
    end else if (cfg_valid) begin
      case (cfg_index)
        ptu_pkg::CFG_MAX_MISSED: max_missed_r <= cfg_data[ptu_pkg::MissW-1:0];
        ptu_pkg::CFG_MAX_IMG:    max_img_r    <= cfg_data[ptu_pkg::ImgDistW-1:0];
        ptu_pkg::CFG_MAX_WLD:    max_wld_r    <= cfg_data[ptu_pkg::WldDistW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_req_r <= ptu_pkg::req_t'(in_tuser);
      s1_ix_r  <= in_tdata[15:0];
      s1_iy_r  <= in_tdata[31:16];
      s1_wx_r  <= in_tdata[55:32];
      s1_wy_r  <= in_tdata[79:56];
    end
  end

  // world distance goes to the origin on push, to the prediction on check
  assign wld_bx = (s1_req_r == ptu_pkg::REQ_PUSH) ? origin_wx_r : guess_wx_r;
  assign wld_by = (s1_req_r == ptu_pkg::REQ_PUSH) ? origin_wy_r : guess_wy_r;

  ptu_dist #(.W(ImgW)) u_img_dist (
    .ax     (s1_ix_r),
    .ay     (s1_iy_r),
    .bx     (guess_ix_r),
    .by     (guess_iy_r),
    .sq_sum (img_sq)
  );

  ptu_dist #(.W(WldW)) u_wld_dist (
    .ax     (s1_wx_r),
    .ay     (s1_wy_r),
    .bx     (wld_bx),
    .by     (wld_by),
    .sq_sum (wld_sq)
  );

  assign prev_ok    = !last_ix_r[ImgW-1] && !last_iy_r[ImgW-1];
  assign missed     = s1_ix_r[ImgW-1] || s1_iy_r[ImgW-1];
  assign miss_inc   = (miss_run_r == '1) ? miss_run_r : miss_run_r + 1'b1;
  assign wld_sq_ext = ptu_pkg::WldDistW'(wld_sq);

  // next path state and result flags
  always_comb begin
    last_ix_nxt     = last_ix_r;
    last_iy_nxt     = last_iy_r;
    last_wx_nxt     = last_wx_r;
    last_wy_nxt     = last_wy_r;
    guess_ix_nxt    = guess_ix_r;
    guess_iy_nxt    = guess_iy_r;
    guess_wx_nxt    = guess_wx_r;
    guess_wy_nxt    = guess_wy_r;
    origin_wx_nxt   = origin_wx_r;
    origin_wy_nxt   = origin_wy_r;
    miss_run_nxt    = miss_run_r;
    frame_total_nxt = frame_total_r;
    far_nxt         = far_r;
    remove_nxt      = 1'b0;
    inear_nxt       = 1'b0;
    wnear_nxt       = 1'b0;
    case (s1_req_r)
      ptu_pkg::REQ_START: begin
        last_ix_nxt     = s1_ix_r;
        last_iy_nxt     = s1_iy_r;
        last_wx_nxt     = s1_wx_r;
        last_wy_nxt     = s1_wy_r;
        guess_ix_nxt    = s1_ix_r;
        guess_iy_nxt    = s1_iy_r;
        guess_wx_nxt    = s1_wx_r;
        guess_wy_nxt    = s1_wy_r;
        origin_wx_nxt   = s1_wx_r;
        origin_wy_nxt   = s1_wy_r;
        miss_run_nxt    = '0;
        frame_total_nxt = ptu_pkg::LenW'(1);
        far_nxt         = '0;
      end
      ptu_pkg::REQ_PUSH: begin
        last_ix_nxt     = s1_ix_r;
        last_iy_nxt     = s1_iy_r;
        last_wx_nxt     = s1_wx_r;
        last_wy_nxt     = s1_wy_r;
        frame_total_nxt = (frame_total_r == '1) ? frame_total_r : frame_total_r + 1'b1;
        if (missed) begin
          miss_run_nxt = miss_inc;
          remove_nxt   = (miss_inc > max_missed_r);
        end else begin
          // constant velocity only after an unbroken valid pair
          if (miss_run_r == '0 && prev_ok) begin
            guess_ix_nxt = ptu_pkg::pred_img(s1_ix_r, last_ix_r);
            guess_iy_nxt = ptu_pkg::pred_img(s1_iy_r, last_iy_r);
            guess_wx_nxt = ptu_pkg::pred_wld(s1_wx_r, last_wx_r);
            guess_wy_nxt = ptu_pkg::pred_wld(s1_wy_r, last_wy_r);
          end else begin
            guess_ix_nxt = s1_ix_r;
            guess_iy_nxt = s1_iy_r;
            guess_wx_nxt = s1_wx_r;
            guess_wy_nxt = s1_wy_r;
          end
          miss_run_nxt = '0;
          if (wld_sq_ext > far_r) begin
            far_nxt = wld_sq_ext;
          end
        end
      end
      ptu_pkg::REQ_CHECK: begin
        inear_nxt = (ptu_pkg::ImgDistW'(img_sq) < max_img_r);
        wnear_nxt = (wld_sq_ext < max_wld_r);
      end
      default: ;
    endcase
  end

  // path state, updated as the item enters the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ix_r     <= '0;
      last_iy_r     <= '0;
      last_wx_r     <= '0;
      last_wy_r     <= '0;
      guess_ix_r    <= '0;
      guess_iy_r    <= '0;
      guess_wx_r    <= '0;
      guess_wy_r    <= '0;
      origin_wx_r   <= '0;
      origin_wy_r   <= '0;
      miss_run_r    <= '0;
      frame_total_r <= '0;
      far_r         <= '0;
    end else if (load) begin
      last_ix_r     <= last_ix_nxt;
      last_iy_r     <= last_iy_nxt;
      last_wx_r     <= last_wx_nxt;
      last_wy_r     <= last_wy_nxt;
      guess_ix_r    <= guess_ix_nxt;
      guess_iy_r    <= guess_iy_nxt;
      guess_wx_r    <= guess_wx_nxt;
      guess_wy_r    <= guess_wy_nxt;
      origin_wx_r   <= origin_wx_nxt;
      origin_wy_r   <= origin_wy_nxt;
      miss_run_r    <= miss_run_nxt;
      frame_total_r <= frame_total_nxt;
      far_r         <= far_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result flags; the rest of the beat is the path state itself
  always_ff @(posedge clk) begin
    if (load) begin
      remove_r <= remove_nxt;
      inear_r  <= inear_nxt;
      wnear_r  <= wnear_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, wnear_r, inear_r,
                       guess_wy_r, guess_wx_r, guess_iy_r, guess_ix_r,
                       far_r, frame_total_r, miss_run_r, remove_r};

`ifndef SYNTHESIS
  // a removal flag always comes with a nonzero miss run
  a_remove_has_misses: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && remove_r |-> miss_run_r != '0)
    else $error("remove_track set with zero missed_count");

  // removal and proximity flags come from different request kinds
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(remove_r && (inear_r || wnear_r)))
    else $error("remove_track and near flags both set");

  // an item waiting in the input register reaches an empty result slot
  a_input_drains: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_valid_r |=> out_valid_r)
    else $error("input register did not move into empty result register");

  // the farthest distance only grows between start items
  a_far_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    load && s1_req_r != ptu_pkg::REQ_START |=> far_r >= $past(far_r))
    else $error("max_dist_sq decreased without a start item");
`endif

endmodule

// File: verif/tb_point_track_update.sv
// tb_point_track_update: self-checking testbench for point_track_update.
// Depends on ptu_pkg (request kinds, register indexes) and the block's RTL.
// Predicts every status beat from a local track model and checks each field.
`timescale 1ns / 100ps

module tb_point_track_update;

  // request kind the block ignores, register index with no register behind it
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [1:0] CFG_SPARE  = 2'd3;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 400;

  // point payload, img_x in the lowest bits
  typedef struct packed {
    logic [23:0] world_y;
    logic [23:0] world_x;
    logic [15:0] img_y;
    logic [15:0] img_x;
  } point_beat_t;

  typedef struct {
    logic [1:0]  kind;
    point_beat_t pt;
  } track_req_t;

  // status payload, remove_track in the lowest bit
  typedef struct packed {
    logic [1:0]  pad;
    logic        world_near;
    logic        image_near;
    logic [23:0] pred_world_y;
    logic [23:0] pred_world_x;
    logic [15:0] pred_img_y;
    logic [15:0] pred_img_x;
    logic [50:0] max_dist_sq;
    logic [15:0] track_length;
    logic [7:0]  missed_count;
    logic        remove_track;
  } track_status_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [79:0]  in_tdata = '0;   // img_x img_y world_x world_y
  logic [1:0]   in_tuser = '0;   // req_type
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [159:0] out_tdata;       // remove_track missed_count track_length max_dist_sq
                                 // pred_img_x pred_img_y pred_world_x pred_world_y
                                 // image_near world_near zero
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [50:0]  cfg_data = '0;

  point_track_update dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  track_req_t    beat_q[$];
  track_status_t status_q[$];

  int  errors = 0;
  int  beats_queued = 0;
  int  beats_in = 0;
  int  beats_out = 0;
  int  reg_writes = 0;
  int  quiet = 0;
  int  hold_left = 0;
  bit  hold_arm = 0;
  bit  calm = 0;
  bit  in_beat_taken = 0;

  // track model: configuration
  logic [7:0]  miss_limit   = ptu_pkg::MaxMissedRst;
  logic [34:0] img_near_lim = ptu_pkg::MaxImgRst;
  logic [50:0] wld_near_lim = ptu_pkg::MaxWldRst;

  // track model: path state
  logic signed [15:0] prev_ix = '0, prev_iy = '0, guess_ix = '0, guess_iy = '0;
  logic signed [23:0] prev_wx = '0, prev_wy = '0, guess_wx = '0, guess_wy = '0;
  logic signed [23:0] home_wx = '0, home_wy = '0;
  logic [7:0]  miss_run = '0;
  logic [15:0] frame_count = '0;
  logic [50:0] peak_dist_sq = '0;

  // 2*cur - prev, clamped to a signed field of w bits
  function automatic longint clamp_step(longint cur, longint prev, int w);
    longint hi, lo, t;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    t = 2 * cur - prev;
    return (t > hi) ? hi : ((t < lo) ? lo : t);
  endfunction

  function automatic longint span_sq(longint ax, longint ay, longint bx, longint by);
    longint dx, dy;
    dx = ax - bx;
    dy = ay - by;
    return dx * dx + dy * dy;
  endfunction

  // advance the track model by one request and queue the status it gives
  task automatic track_predict(input logic [1:0] kind, input point_beat_t pt);
    track_status_t st;
    longint ix, iy, wx, wy, d;
    logic prev_ok;
    ix = longint'($signed(pt.img_x));
    iy = longint'($signed(pt.img_y));
    wx = longint'($signed(pt.world_x));
    wy = longint'($signed(pt.world_y));
    st = '0;
    case (kind)
      ptu_pkg::REQ_START: begin
        prev_ix = pt.img_x;   guess_ix = pt.img_x;
        prev_iy = pt.img_y;   guess_iy = pt.img_y;
        prev_wx = pt.world_x; guess_wx = pt.world_x; home_wx = pt.world_x;
        prev_wy = pt.world_y; guess_wy = pt.world_y; home_wy = pt.world_y;
        miss_run = '0;
        frame_count = 16'd1;
        peak_dist_sq = '0;
      end
      ptu_pkg::REQ_PUSH: begin
        prev_ok = !prev_ix[15] && !prev_iy[15];
        if (frame_count != 16'hFFFF) frame_count = frame_count + 16'd1;
        if (ix < 0 || iy < 0) begin
          if (miss_run != 8'hFF) miss_run = miss_run + 8'd1;
          st.remove_track = miss_run > miss_limit;
        end else begin
          if (miss_run == 8'd0 && prev_ok) begin
            guess_ix = 16'(clamp_step(ix, longint'(prev_ix), 16));
            guess_iy = 16'(clamp_step(iy, longint'(prev_iy), 16));
            guess_wx = 24'(clamp_step(wx, longint'(prev_wx), 24));
            guess_wy = 24'(clamp_step(wy, longint'(prev_wy), 24));
          end else begin
            guess_ix = pt.img_x;
            guess_iy = pt.img_y;
            guess_wx = pt.world_x;
            guess_wy = pt.world_y;
          end
          miss_run = '0;
          d = span_sq(wx, wy, longint'(home_wx), longint'(home_wy));
          if (d > longint'(peak_dist_sq)) peak_dist_sq = 51'(d);
        end
        prev_ix = pt.img_x;
        prev_iy = pt.img_y;
        prev_wx = pt.world_x;
        prev_wy = pt.world_y;
      end
      ptu_pkg::REQ_CHECK: begin
        st.image_near = span_sq(ix, iy, longint'(guess_ix), longint'(guess_iy))
                        < longint'(img_near_lim);
        st.world_near = span_sq(wx, wy, longint'(guess_wx), longint'(guess_wy))
                        < longint'(wld_near_lim);
      end
      default: ;
    endcase
    st.missed_count = miss_run;
    st.track_length = frame_count;
    st.max_dist_sq  = peak_dist_sq;
    st.pred_img_x   = guess_ix;
    st.pred_img_y   = guess_iy;
    st.pred_world_x = guess_wx;
    st.pred_world_y = guess_wy;
    status_q.push_back(st);
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // input side: accept beats and run the model on each
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      track_predict(in_tuser, in_tdata);
      in_beat_taken = 1;
      beats_in++;
    end
  end

  // configuration side: mirror every register write into the model
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        ptu_pkg::CFG_MAX_MISSED: miss_limit   = cfg_data[7:0];
        ptu_pkg::CFG_MAX_IMG:    img_near_lim = cfg_data[34:0];
        ptu_pkg::CFG_MAX_WLD:    wld_near_lim = cfg_data;
        default: ;
      endcase
      reg_writes++;
    end
  end

  // result side: compare each status beat with the oldest prediction
  always @(posedge clk) begin
    track_status_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      beats_out++;
      if (status_q.size() == 0) begin
        errors++;
        $display("%0t ns: status beat with none expected, expected none, actual 0x%0h",
                 $time, out_tdata);
      end else begin
        want = status_q.pop_front();
        check_field("remove_track", 64'(want.remove_track), 64'(got.remove_track));
        check_field("missed_count", 64'(want.missed_count), 64'(got.missed_count));
        check_field("track_length", 64'(want.track_length), 64'(got.track_length));
        check_field("max_dist_sq",  64'(want.max_dist_sq),  64'(got.max_dist_sq));
        check_field("pred_img_x",   64'(want.pred_img_x),   64'(got.pred_img_x));
        check_field("pred_img_y",   64'(want.pred_img_y),   64'(got.pred_img_y));
        check_field("pred_world_x", 64'(want.pred_world_x), 64'(got.pred_world_x));
        check_field("pred_world_y", 64'(want.pred_world_y), 64'(got.pred_world_y));
        check_field("image_near",   64'(want.image_near),   64'(got.image_near));
        check_field("world_near",   64'(want.world_near),   64'(got.world_near));
        check_field("pad",          64'(want.pad),          64'(got.pad));
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet == QuietLimit) begin
        $display("%0t ns: no beat for %0d cycles", $time, QuietLimit);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // driver: present queued beats with random gaps, hold each until taken
  always @(negedge clk) begin
    track_req_t nxt;
    if (rst_n && (!in_tvalid || in_beat_taken)) begin
      if (beat_q.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
        nxt = beat_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= nxt.kind;
        in_tdata  <= nxt.pt;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    in_beat_taken = 0;
  end

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_arm) begin
      hold_arm = 0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 7);
    end
  end

  function automatic int rand_signed(int m);
    int t;
    t = $urandom_range(2 * m);
    return t - m;
  endfunction

  function automatic int clampi(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic queue_item(input logic [1:0] kind, input int ix, input int iy,
                            input int wx, input int wy);
    track_req_t r;
    r.kind = kind;
    r.pt.img_x   = ix[15:0];
    r.pt.img_y   = iy[15:0];
    r.pt.world_x = wx[23:0];
    r.pt.world_y = wy[23:0];
    beat_q.push_back(r);
    if (kind != REQ_UNUSED) beats_queued++;
  endtask

  // one missed frame: negative x, negative y, or both
  task automatic queue_miss(input int wx, input int wy);
    int mode, nx, ny;
    mode = $urandom_range(2);
    nx = $urandom_range(1, 32768);
    ny = $urandom_range(1, 32768);
    queue_item(ptu_pkg::REQ_PUSH, (mode != 1) ? -nx : $urandom_range(32767),
               (mode != 0) ? -ny : $urandom_range(32767), wx, wy);
  endtask

  // random tracks: start, pushes at a steady velocity, miss runs, checks near
  // the current point; a few beats of full-range noise mixed in
  task automatic feed_tracks(input int n);
    int first, gx, gy, gwx, gwy, vx, vy, vwx, vwy, steps, k, burst;
    bit fast;
    first = beats_queued;
    while (beats_queued - first < n) begin
      if ($urandom_range(99) < 8) begin
        queue_item(2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom);
      end else begin
        fast = $urandom_range(9) == 0;
        gx  = $urandom_range(32767);
        gy  = $urandom_range(32767);
        gwx = rand_signed(8388607);
        gwy = rand_signed(8388607);
        vx  = fast ? rand_signed(8000) : rand_signed(60);
        vy  = fast ? rand_signed(8000) : rand_signed(60);
        vwx = fast ? rand_signed(2000000) : rand_signed(200);
        vwy = fast ? rand_signed(2000000) : rand_signed(200);
        queue_item(ptu_pkg::REQ_START, gx, gy, gwx, gwy);
        steps = $urandom_range(3, 20);
        repeat (steps) begin
          k = $urandom_range(99);
          if (k < 65) begin
            gx  = clampi(gx + vx, 0, 32767);
            gy  = clampi(gy + vy, 0, 32767);
            gwx = clampi(gwx + vwx, -8388608, 8388607);
            gwy = clampi(gwy + vwy, -8388608, 8388607);
            queue_item(ptu_pkg::REQ_PUSH, gx, gy, gwx, gwy);
          end else if (k < 80) begin
            burst = $urandom_range(1, 8);
            repeat (burst) queue_miss(gwx + rand_signed(300), gwy + rand_signed(300));
          end else begin
            queue_item(ptu_pkg::REQ_CHECK, gx + rand_signed(150), gy + rand_signed(150),
                       gwx + rand_signed(500), gwy + rand_signed(500));
          end
        end
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [50:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // block is idle once every queued beat went in and every status came back
  task automatic wait_idle;
    do @(negedge clk); while (beat_q.size() != 0 || in_tvalid || status_q.size() != 0);
  endtask

  initial begin
    int i, gx, gy;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset limits, saturation, misses, distance boundaries
    queue_item(ptu_pkg::REQ_PUSH, 100, 200, 1000, -1000);
    queue_item(ptu_pkg::REQ_CHECK, 0, 0, 0, 0);
    queue_item(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom);
    queue_item(ptu_pkg::REQ_START, 0, 0, -8388608, 8388607);
    queue_item(ptu_pkg::REQ_PUSH, 32767, 32767, 8388607, -8388608);
    queue_item(ptu_pkg::REQ_PUSH, 0, 0, -8388608, 8388607);
    queue_item(ptu_pkg::REQ_CHECK, -32767, -32767, -8388608, 8388607);
    queue_item(ptu_pkg::REQ_CHECK, 32767, 32767, 8388607, -8388608);
    queue_item(ptu_pkg::REQ_PUSH, -32768, 10, 0, 0);
    queue_item(ptu_pkg::REQ_PUSH, 10, -1, 0, 0);
    queue_item(ptu_pkg::REQ_PUSH, -1, -32768, 0, 0);
    queue_item(ptu_pkg::REQ_PUSH, -32768, -32768, 8388607, 8388607);
    queue_item(ptu_pkg::REQ_PUSH, -5, 5, 0, 0);
    queue_item(ptu_pkg::REQ_PUSH, 5, -5, 0, 0);
    queue_item(ptu_pkg::REQ_PUSH, -7, -7, -8388608, -8388608);
    queue_item(ptu_pkg::REQ_PUSH, 1000, 2000, 5000, 6000);
    queue_item(ptu_pkg::REQ_PUSH, 1010, 2010, 5100, 6100);
    queue_item(ptu_pkg::REQ_CHECK, 1100, 2020, 5456, 6200);
    queue_item(ptu_pkg::REQ_CHECK, 1099, 2020, 5455, 6200);
    queue_item(ptu_pkg::REQ_START, 32767, 32767, 8388607, 8388607);
    queue_item(REQ_UNUSED, -1, -1, -1, -1);
    queue_item(ptu_pkg::REQ_CHECK, 32767, 32767, 8388607, 8388607);
    feed_tracks(80);
    wait_idle();

    // tightest limits: nothing counts as near, first miss removes
    write_reg(ptu_pkg::CFG_MAX_MISSED, '0);
    write_reg(ptu_pkg::CFG_MAX_IMG, '0);
    write_reg(ptu_pkg::CFG_MAX_WLD, '0);
    feed_tracks(40);
    wait_idle();

    // widest limits, plus a miss run long enough to pin the counter
    write_reg(ptu_pkg::CFG_MAX_MISSED, 51'd254);
    write_reg(ptu_pkg::CFG_MAX_IMG, {35{1'b1}});
    write_reg(ptu_pkg::CFG_MAX_WLD, {51{1'b1}});
    write_reg(CFG_SPARE, {51{1'b1}});
    queue_item(ptu_pkg::REQ_START, 500, 500, 0, 0);
    repeat (260) queue_miss(rand_signed(1000), rand_signed(1000));
    queue_item(ptu_pkg::REQ_PUSH, 600, 600, 100, 100);
    feed_tracks(40);
    wait_idle();

    // mid-range limits, with a long output hold-off while input keeps coming
    write_reg(ptu_pkg::CFG_MAX_MISSED, 51'($urandom_range(1, 20)));
    write_reg(ptu_pkg::CFG_MAX_IMG, 51'($urandom_range(100, 40000)));
    write_reg(ptu_pkg::CFG_MAX_WLD, 51'($urandom_range(1000, 500000)));
    feed_tracks(80);
    hold_arm = 1;
    wait_idle();

    // back-to-back pushes and misses with no gaps on either side
    calm = 1;
    gx = 16000;
    gy = 16000;
    for (i = 0; i < 100; i++) begin
      if ($urandom_range(9) == 0) begin
        queue_miss(rand_signed(5000), rand_signed(5000));
      end else begin
        gx = clampi(gx + rand_signed(40), 0, 32767);
        gy = clampi(gy + rand_signed(40), 0, 32767);
        queue_item(ptu_pkg::REQ_PUSH, gx, gy, rand_signed(8388607), rand_signed(8388607));
      end
    end
    wait_idle();
    calm = 0;

    repeat (8) @(posedge clk);
    if (status_q.size() != 0) begin
      errors++;
      $display("%0t ns: status beats missing, expected %0d more, actual 0",
               $time, status_q.size());
    end
    $display("run: %0d request beats in, %0d status beats out, %0d register writes",
             beats_in, beats_out, reg_writes);
    $display("covered: four limit settings, saturated predictions and miss count, long stall");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
